// File: rtl/core/dre_pkg.sv
// Shared types and constants for the decimal to Roman numeral encoder.
// Holds the numeral token table and the controller to datapath interface.
// No dependencies.
package dre_pkg;

    localparam int VALUE_W  = 16;
    localparam int LETTER_W = 7;
    localparam int REM_W    = 12;
    localparam int IDX_W    = 4;

    localparam logic [IDX_W-1:0] LAST_TOKEN = 4'd12;

    localparam logic [LETTER_W-1:0] CHAR_NONE = 7'h00;
    localparam logic [LETTER_W-1:0] CHAR_I    = 7'h49;
    localparam logic [LETTER_W-1:0] CHAR_V    = 7'h56;
    localparam logic [LETTER_W-1:0] CHAR_X    = 7'h58;
    localparam logic [LETTER_W-1:0] CHAR_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] CHAR_C    = 7'h43;
    localparam logic [LETTER_W-1:0] CHAR_D    = 7'h44;
    localparam logic [LETTER_W-1:0] CHAR_M    = 7'h4D;

    typedef struct packed {
        logic [REM_W-1:0]    weight;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                pair;
    } token_t;

    typedef struct packed {
        logic load;
        logic flag_error;
        logic step;
    } dre_cmd_t;

    typedef struct packed {
        logic in_range;
        logic final_letter;
    } dre_status_t;

    function automatic token_t token_lookup(input logic [IDX_W-1:0] idx);
        token_t t;
        unique case (idx)
            4'd0:    t = '{12'd1000, CHAR_M, CHAR_NONE, 1'b0};
            4'd1:    t = '{12'd900,  CHAR_C, CHAR_M,    1'b1};
            4'd2:    t = '{12'd500,  CHAR_D, CHAR_NONE, 1'b0};
            4'd3:    t = '{12'd400,  CHAR_C, CHAR_D,    1'b1};
            4'd4:    t = '{12'd100,  CHAR_C, CHAR_NONE, 1'b0};
            4'd5:    t = '{12'd90,   CHAR_X, CHAR_C,    1'b1};
            4'd6:    t = '{12'd50,   CHAR_L, CHAR_NONE, 1'b0};
            4'd7:    t = '{12'd40,   CHAR_X, CHAR_L,    1'b1};
            4'd8:    t = '{12'd10,   CHAR_X, CHAR_NONE, 1'b0};
            4'd9:    t = '{12'd9,    CHAR_I, CHAR_X,    1'b1};
            4'd10:   t = '{12'd5,    CHAR_V, CHAR_NONE, 1'b0};
            4'd11:   t = '{12'd4,    CHAR_I, CHAR_V,    1'b1};
            default: t = '{12'd1,    CHAR_I, CHAR_NONE, 1'b0};
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/dre_datapath.sv
// Datapath of the Roman numeral encoder: remainder, token index and result registers.
// Depends on dre_pkg.
module dre_datapath #(
    parameter int LARGEST_VALUE = 3999
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dre_pkg::VALUE_W-1:0]       value,
    input  dre_pkg::dre_cmd_t                 cmd,
    output dre_pkg::dre_status_t              status,
    output logic [dre_pkg::LETTER_W-1:0]      letter,
    output logic                              last,
    output logic                              range_error,
    output logic                              result_valid
);
    import dre_pkg::*;

    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                second_reg, second_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                last_reg, last_next;
    logic                err_reg, err_next;
    logic                strobe_reg, strobe_next;

    token_t              tok;
    logic                hit;
    logic [REM_W-1:0]    diff;

    assign tok  = token_lookup(idx_reg);
    assign hit  = rem_reg >= tok.weight;
    assign diff = rem_reg - tok.weight;

    assign status.in_range     = (value != '0) && (value <= VALUE_W'(LARGEST_VALUE));
    assign status.final_letter = (second_reg || (hit && !tok.pair)) && (diff == '0);

    always_comb
    begin
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        second_next = second_reg;
        letter_next = letter_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        strobe_next = 1'b0;
        if (cmd.load)
        begin
            rem_next    = value[REM_W-1:0];
            idx_next    = '0;
            second_next = 1'b0;
        end
        else if (cmd.flag_error)
        begin
            letter_next = CHAR_NONE;
            last_next   = 1'b1;
            err_next    = 1'b1;
            strobe_next = 1'b1;
        end
        else if (cmd.step)
        begin
            err_next = 1'b0;
            if (second_reg)
            begin
                letter_next = tok.second;
                rem_next    = diff;
                second_next = 1'b0;
                last_next   = (diff == '0);
                strobe_next = 1'b1;
            end
            else if (hit)
            begin
                letter_next = tok.first;
                strobe_next = 1'b1;
                if (tok.pair)
                begin
                    second_next = 1'b1;
                    last_next   = 1'b0;
                end
                else
                begin
                    rem_next  = diff;
                    last_next = (diff == '0);
                end
            end
            else
            begin
                idx_next = IDX_W'(idx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            idx_reg    <= '0;
            second_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
            second_reg <= second_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

    assign letter       = letter_reg;
    assign last         = last_reg;
    assign range_error  = err_reg;
    assign result_valid = strobe_reg;

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && err_reg) |-> (last_reg && letter_reg == CHAR_NONE))
        else $error("Error result must carry a null letter and be the last one.");

    a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (second_reg && cmd.step) |=> (!second_reg && strobe_reg))
        else $error("Second letter of a pair was not emitted.");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_TOKEN)
        else $error("Token index ran past the end of the table.");

endmodule

// File: rtl/core/dre_controller.sv
// Controller of the Roman numeral encoder: accepts a command and sequences the datapath.
// Depends on dre_pkg.
module dre_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dre_pkg::dre_status_t status,
    output dre_pkg::dre_cmd_t    cmd,
    output logic                 busy
);
    import dre_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.flag_error = 1'b0;
        cmd.step       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.in_range)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.flag_error = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.final_letter)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_RUN);

endmodule

// File: rtl/core/decimal_to_roman_encoder_core.sv
// Top level of the decimal to Roman numeral encoder.
// Depends on dre_pkg, dre_controller and dre_datapath.
//
// A value is taken at a clock edge where start is high and busy is low. Its Roman
// numeral leaves one letter per result_valid pulse, reading order, last set on the
// final letter; each result is shown for one cycle only and is never held back. The
// datapath walks a thirteen-row token table (M, CM, D, CD, ... IV, I): each cycle it
// emits one letter or moves to the next row. A value of 0 or above LARGEST_VALUE
// gives one flagged result and leaves busy low, so the next transfer can follow in
// the next cycle.
module decimal_to_roman_encoder_core #(
    parameter int LARGEST_VALUE = 3999
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dre_pkg::VALUE_W-1:0]   value,
    output logic                          result_valid,
    output logic [dre_pkg::LETTER_W-1:0]  letter,
    output logic                          last,
    output logic                          range_error
);
    import dre_pkg::*;

    dre_cmd_t    cmd;
    dre_status_t status;

    dre_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dre_datapath #(
        .LARGEST_VALUE (LARGEST_VALUE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .status       (status),
        .letter       (letter),
        .last         (last),
        .range_error  (range_error),
        .result_valid (result_valid)
    );

endmodule

// File: bench/tb_decimal_to_roman_encoder_core.sv
`timescale 1ns / 1ps
// Testbench for decimal_to_roman_encoder_core: drives values and checks every Roman letter.
// It spells each accepted value itself and compares the letters in the order they arrive.
// Depends on dre_pkg and the encoder core RTL.
class numeral_checker;

    typedef struct {
        logic [dre_pkg::LETTER_W-1:0] letter;
        logic                         last;
        logic                         range_error;
    } spelled_letter_t;

    spelled_letter_t pending_letters[$];
    int unsigned     mismatches;
    int unsigned     largest;

    function new(int unsigned largest_value);
        largest    = largest_value;
        mismatches = 0;
    endfunction

    function void push_letter(logic [dre_pkg::LETTER_W-1:0] ch, logic is_last, logic err);
        spelled_letter_t item;
        item.letter      = ch;
        item.last        = is_last;
        item.range_error = err;
        pending_letters.push_back(item);
    endfunction

    function void note_value(logic [dre_pkg::VALUE_W-1:0] v);
        logic [dre_pkg::LETTER_W-1:0] ones[3];
        logic [dre_pkg::LETTER_W-1:0] fives[3];
        logic [dre_pkg::LETTER_W-1:0] tens[3];
        int unsigned scale[3];
        int unsigned digit;
        int unsigned count;
        int          decade;
        ones[0]  = dre_pkg::CHAR_I;
        ones[1]  = dre_pkg::CHAR_X;
        ones[2]  = dre_pkg::CHAR_C;
        fives[0] = dre_pkg::CHAR_V;
        fives[1] = dre_pkg::CHAR_L;
        fives[2] = dre_pkg::CHAR_D;
        tens[0]  = dre_pkg::CHAR_X;
        tens[1]  = dre_pkg::CHAR_C;
        tens[2]  = dre_pkg::CHAR_M;
        scale[0] = 1;
        scale[1] = 10;
        scale[2] = 100;
        if (v == 0 || v > largest)
        begin
            push_letter(dre_pkg::CHAR_NONE, 1'b1, 1'b1);
            return;
        end
        count = pending_letters.size();
        for (int k = 0; k < v / 1000; k++)
            push_letter(dre_pkg::CHAR_M, 1'b0, 1'b0);
        for (decade = 2; decade >= 0; decade--)
        begin
            digit = (v / scale[decade]) % 10;
            if (digit == 9)
            begin
                push_letter(ones[decade], 1'b0, 1'b0);
                push_letter(tens[decade], 1'b0, 1'b0);
            end
            else if (digit == 4)
            begin
                push_letter(ones[decade], 1'b0, 1'b0);
                push_letter(fives[decade], 1'b0, 1'b0);
            end
            else
            begin
                if (digit >= 5)
                begin
                    push_letter(fives[decade], 1'b0, 1'b0);
                    digit -= 5;
                end
                for (int k = 0; k < digit; k++)
                    push_letter(ones[decade], 1'b0, 1'b0);
            end
        end
        if (pending_letters.size() > count)
            pending_letters[pending_letters.size() - 1].last = 1'b1;
    endfunction

    function void check_letter(logic [dre_pkg::LETTER_W-1:0] ch, logic is_last, logic err);
        spelled_letter_t want;
        if (pending_letters.size() == 0)
        begin
            $error("letter %0d arrived with no numeral pending", ch);
            mismatches++;
            return;
        end
        want = pending_letters.pop_front();
        if (ch !== want.letter)
        begin
            $error("letter: expected %0d, got %0d", want.letter, ch);
            mismatches++;
        end
        if (is_last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, is_last);
            mismatches++;
        end
        if (err !== want.range_error)
        begin
            $error("range_error: expected %0d, got %0d", want.range_error, err);
            mismatches++;
        end
    endfunction

endclass

module tb_decimal_to_roman_encoder_core;

    localparam int          LARGEST_VALUE = 3999;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [dre_pkg::VALUE_W-1:0]   value;
    logic                          result_valid;
    logic [dre_pkg::LETTER_W-1:0]  letter;
    logic                          last;
    logic                          range_error;

    numeral_checker numerals;
    int unsigned    cycle_count;

    decimal_to_roman_encoder_core #(
        .LARGEST_VALUE(LARGEST_VALUE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .result_valid(result_valid),
        .letter(letter),
        .last(last),
        .range_error(range_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                numerals.note_value(value);
            if (result_valid)
                numerals.check_letter(letter, last, range_error);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_value(input logic [dre_pkg::VALUE_W-1:0] v, input bit may_idle);
        int unsigned gap;
        gap = 0;
        if (may_idle && $urandom_range(99) < 21)
            gap = $urandom_range(30, 1);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [dre_pkg::VALUE_W-1:0] random_value();
        int unsigned pick;
        int unsigned draw;
        pick = $urandom_range(99);
        if (pick < 82)
            draw = $urandom_range(LARGEST_VALUE, 1);
        else if (pick < 88)
            draw = $urandom_range(LARGEST_VALUE + 10, LARGEST_VALUE - 10);
        else if (pick < 91)
            draw = 0;
        else
            draw = $urandom_range(65535, LARGEST_VALUE + 1);
        return draw[dre_pkg::VALUE_W-1:0];
    endfunction

    initial
    begin
        logic [dre_pkg::VALUE_W-1:0] directed[$];
        numerals    = new(LARGEST_VALUE);
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        directed = '{16'd0, 16'd1, 16'd3999, 16'd4000, 16'd65535, 16'd3888, 16'd4,
                     16'd9, 16'd40, 16'd90, 16'd400, 16'd900, 16'd5, 16'd10, 16'd50,
                     16'd100, 16'd500, 16'd1000, 16'd3, 16'd8, 16'd1444, 16'd999,
                     16'd49, 16'd2468, 16'd32768};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_value(directed[i], 1'b1);
        for (int i = 0; i < 75; i++)
            send_value(random_value(), !(i >= 30 && i < 70));
        start <= 1'b0;
        @(posedge clk);
        while (numerals.pending_letters.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (numerals.mismatches == 0 && numerals.pending_letters.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
